// ===== hw/rtl/sitq_pkg.sv =====
// shared types and codes for the sparse index ordered table
`default_nettype none
package sitq_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int HANDLE_W      = 32;
  localparam int INDEX_W       = 8;
  localparam int PREALLOC_W    = 9;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_GET_NEXT = 3'd3;
  localparam logic [2:0] OP_FIND     = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [INDEX_W-1:0]  index;
    logic                cursor_start;
    logic [HANDLE_W-1:0] item_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] item_out;
    logic [INDEX_W-1:0]  index_out;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sitq_mem.sv =====
// single port pair table memory with registered read data
`default_nettype none
module sitq_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 42
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sparse_index_ordered_table_core.sv =====
// top level: sequencer over the linked table memory
//
//  port group   direction  handshake            payload
//  in_*         input      in_valid / in_stall   sitq_pkg::in_item_t
//  out_*        output     out_valid / out_stall sitq_pkg::out_item_t
//  cfg_*        input      cfg_valid / cfg_ready prealloc_entries, 9 bits
//
// one item at a time; every table access is one read or one write of the single memory
// get reads its entry, get next the cursor entry and its successor, find free scans
// from entry 0 up to its bound; add and remove may walk the chain entries below index
// after reset a clearing pass writes every entry before the first item
// a waiting result blocks new items until taken; cfg_ready is always high
`default_nettype none
module sparse_index_ordered_table_core #(
  parameter int TABLE_DEPTH = sitq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire sitq_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sitq_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sitq_pkg::PREALLOC_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int HW = sitq_pkg::HANDLE_W;
  localparam int WW = 1 + LW + HW;
  localparam int BW = ((LW > sitq_pkg::PREALLOC_W) ? LW : sitq_pkg::PREALLOC_W) + 1;
  localparam logic [LW-1:0] NONE = LW'(TABLE_DEPTH);
  localparam logic [LW-1:0] LAST_ENTRY = LW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_GET      = 4'd2;
  localparam logic [3:0] S_NX_CUR   = 4'd3;
  localparam logic [3:0] S_NX_DATA  = 4'd4;
  localparam logic [3:0] S_ADD_CHK  = 4'd5;
  localparam logic [3:0] S_ADD_WALK = 4'd6;
  localparam logic [3:0] S_ADD_LINK = 4'd7;
  localparam logic [3:0] S_REM_CHK  = 4'd8;
  localparam logic [3:0] S_REM_WALK = 4'd9;
  localparam logic [3:0] S_REM_CLR  = 4'd10;
  localparam logic [3:0] S_FREE     = 4'd11;

  logic [3:0]  state, state_next;
  logic [LW-1:0] op_idx, op_idx_next;
  logic [HW-1:0] op_handle, op_handle_next;
  logic [LW-1:0] first, first_next;
  logic [LW-1:0] last, last_next;
  logic [LW-1:0] highest, highest_next;
  logic [LW-1:0] walk, walk_next;
  logic [LW-1:0] link, link_next;
  logic [LW-1:0] scan, scan_next;
  logic [LW-1:0] bound, bound_next;
  logic [sitq_pkg::PREALLOC_W-1:0] prealloc;
  sitq_pkg::out_item_t out_next;
  logic out_valid_next;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] rd_data, wr_data;
  logic          rd_valid;
  logic [LW-1:0] rd_link;
  logic [HW-1:0] rd_item;

  logic          in_acc, in_range;
  logic [LW-1:0] in_idx;
  logic [BW-1:0] bound_wide, hp1;
  logic [LW-1:0] bound_c;
  logic          highest_upd;

  sitq_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign rd_valid = rd_data[WW-1];
  assign rd_link  = rd_data[HW +: LW];
  assign rd_item  = rd_data[HW-1:0];

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign in_range  = 32'(in_data.index) < 32'(TABLE_DEPTH);
  assign in_idx    = LW'(in_data.index);

  // find free bound: higher of prealloc and one past highest added, clipped
  always_comb begin
    hp1 = (highest == NONE) ? '0 : BW'(highest) + BW'(1);
    bound_wide = (hp1 > BW'(prealloc)) ? hp1 : BW'(prealloc);
    if (bound_wide > BW'(TABLE_DEPTH)) begin
      bound_wide = BW'(TABLE_DEPTH);
    end
    bound_c = LW'(bound_wide);
  end

  assign highest_upd = (highest == NONE) || (op_idx > highest);

  always_comb begin
    state_next     = state;
    op_idx_next    = op_idx;
    op_handle_next = op_handle;
    first_next     = first;
    last_next      = last;
    highest_next   = highest;
    walk_next      = walk;
    link_next      = link;
    scan_next      = scan;
    bound_next     = bound;
    out_next       = out_data;
    out_valid_next = out_valid && out_stall;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    case (state)
      S_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = scan[AW-1:0];
        scan_next = scan + LW'(1);
        if (scan == LAST_ENTRY) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_idx_next    = in_idx;
          op_handle_next = in_data.item_handle;
          rd_addr        = in_idx[AW-1:0];
          out_next       = '{status: sitq_pkg::ST_MISS, item_out: '0, index_out: '0};
          case (in_data.opcode)
            sitq_pkg::OP_ADD, sitq_pkg::OP_REMOVE, sitq_pkg::OP_GET: begin
              if (!in_range) begin
                out_valid_next = 1'b1;
              end else begin
                rd_en = 1'b1;
                case (in_data.opcode)
                  sitq_pkg::OP_ADD:    state_next = S_ADD_CHK;
                  sitq_pkg::OP_REMOVE: state_next = S_REM_CHK;
                  default:             state_next = S_GET;
                endcase
              end
            end
            sitq_pkg::OP_GET_NEXT: begin
              if (in_data.cursor_start) begin
                if (first == NONE) begin
                  out_valid_next = 1'b1;
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = first[AW-1:0];
                  walk_next  = first;
                  state_next = S_NX_DATA;
                end
              end else if (!in_range) begin
                out_next.index_out = in_data.index;
                out_valid_next     = 1'b1;
              end else begin
                rd_en      = 1'b1;
                state_next = S_NX_CUR;
              end
            end
            sitq_pkg::OP_FIND: begin
              if (bound_c == '0) begin
                out_next.status = sitq_pkg::ST_NO_FREE;
                out_valid_next  = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                scan_next  = LW'(1);
                bound_next = bound_c;
                state_next = S_FREE;
              end
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        out_next = rd_valid
          ? '{status: sitq_pkg::ST_OK, item_out: rd_item, index_out: '0}
          : '{status: sitq_pkg::ST_MISS, item_out: '0, index_out: '0};
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_NX_CUR: begin
        if (!rd_valid || rd_link >= NONE) begin
          out_next = '{status: sitq_pkg::ST_MISS, item_out: '0,
                       index_out: sitq_pkg::INDEX_W'(op_idx)};
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = rd_link[AW-1:0];
          walk_next  = rd_link;
          state_next = S_NX_DATA;
        end
      end
      S_NX_DATA: begin
        out_next = '{status: sitq_pkg::ST_OK, item_out: rd_item,
                     index_out: sitq_pkg::INDEX_W'(walk)};
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_ADD_CHK: begin
        if (rd_valid) begin
          // occupied slot: only the handle changes
          wr_en   = 1'b1;
          wr_addr = op_idx[AW-1:0];
          wr_data = {1'b1, rd_link, op_handle};
          if (highest_upd) begin
            highest_next = op_idx;
          end
          out_next       = '{status: sitq_pkg::ST_OK, item_out: '0, index_out: '0};
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else if (first < op_idx) begin
          rd_en      = 1'b1;
          rd_addr    = first[AW-1:0];
          walk_next  = first;
          state_next = S_ADD_WALK;
        end else begin
          link_next  = first;
          first_next = op_idx;
          state_next = S_ADD_LINK;
        end
      end
      S_ADD_WALK: begin
        if (rd_link < op_idx) begin
          rd_en     = 1'b1;
          rd_addr   = rd_link[AW-1:0];
          walk_next = rd_link;
        end else begin
          // predecessor found: point it at the new entry
          wr_en      = 1'b1;
          wr_addr    = walk[AW-1:0];
          wr_data    = {rd_valid, op_idx, rd_item};
          link_next  = rd_link;
          state_next = S_ADD_LINK;
        end
      end
      S_ADD_LINK: begin
        wr_en   = 1'b1;
        wr_addr = op_idx[AW-1:0];
        wr_data = {1'b1, link, op_handle};
        if (link == NONE) begin
          last_next = op_idx;
        end
        if (highest_upd) begin
          highest_next = op_idx;
        end
        out_next       = '{status: sitq_pkg::ST_OK, item_out: '0, index_out: '0};
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_REM_CHK: begin
        if (!rd_valid) begin
          out_next       = '{status: sitq_pkg::ST_MISS, item_out: '0, index_out: '0};
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else if (first == op_idx) begin
          link_next  = rd_link;
          first_next = rd_link;
          if (last == op_idx) begin
            last_next = NONE;
          end
          state_next = S_REM_CLR;
        end else begin
          link_next  = rd_link;
          rd_en      = 1'b1;
          rd_addr    = first[AW-1:0];
          walk_next  = first;
          state_next = S_REM_WALK;
        end
      end
      S_REM_WALK: begin
        if (rd_link == op_idx) begin
          wr_en   = 1'b1;
          wr_addr = walk[AW-1:0];
          wr_data = {rd_valid, link, rd_item};
          if (last == op_idx) begin
            last_next = walk;
          end
          state_next = S_REM_CLR;
        end else if (rd_link >= NONE) begin
          state_next = S_REM_CLR;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = rd_link[AW-1:0];
          walk_next = rd_link;
        end
      end
      S_REM_CLR: begin
        wr_en          = 1'b1;
        wr_addr        = op_idx[AW-1:0];
        wr_data        = '0;
        out_next       = '{status: sitq_pkg::ST_OK, item_out: '0, index_out: '0};
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_FREE: begin
        // read data belongs to entry scan - 1
        if (!rd_valid) begin
          out_next = '{status: sitq_pkg::ST_OK, item_out: '0,
                       index_out: sitq_pkg::INDEX_W'(scan - LW'(1))};
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else if (scan >= bound) begin
          out_next = '{status: sitq_pkg::ST_NO_FREE, item_out: '0, index_out: '0};
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = scan[AW-1:0];
          scan_next = scan + LW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan      <= '0;
      first     <= NONE;
      last      <= NONE;
      highest   <= NONE;
      prealloc  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan      <= scan_next;
      first     <= first_next;
      last      <= last_next;
      highest   <= highest_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        prealloc <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_idx    <= op_idx_next;
    op_handle <= op_handle_next;
    walk      <= walk_next;
    link      <= link_next;
    bound     <= bound_next;
    out_data  <= out_next;
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("item accepted during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in progress");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((first == NONE) == (last == NONE)))
    else $error("chain head and tail disagree on empty");

  a_ends_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && first != NONE) |-> (first <= last))
    else $error("chain head above chain tail");

  a_single_access_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE) |-> !wr_en)
    else $error("table written during free search");

endmodule
`default_nettype wire
